// File: rtl/bfk_pkg.sv
// Shared constants, types and helper functions of the Blowfish keycode engine.
package bfk_pkg;

  localparam int P_WORDS     = 18;
  localparam int ROUNDS      = 16;
  localparam int SBOX_WORDS  = 256;
  localparam int S_WORDS     = 4 * SBOX_WORDS;
  localparam int S_AW        = $clog2(S_WORDS);
  localparam int TABLE_WORDS = P_WORDS + S_WORDS;
  localparam int ROUND_W     = $clog2(ROUNDS);
  localparam int P_IW        = $clog2(P_WORDS);

  typedef logic [1:0] action_t;
  localparam action_t ACT_LOAD = 2'd0;
  localparam action_t ACT_KEY  = 2'd1;
  localparam action_t ACT_ENC  = 2'd2;

  typedef logic [P_WORDS-1:0][31:0] p_words_t;

  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
  } half_pair_t;

  function automatic logic [31:0] swap_bytes(input logic [31:0] v);
    return {v[7:0], v[15:8], v[23:16], v[31:24]};
  endfunction

endpackage

// File: rtl/bfk_if.sv
// Valid/ready channel interfaces for the input and result words.
interface bfk_in_if import bfk_pkg::*; ();
  logic        valid;
  logic        ready;
  action_t     action;
  logic [10:0] table_index;
  logic [31:0] table_word;
  logic [31:0] key_seed;
  logic [63:0] block_in;

  modport source(output valid, action, table_index, table_word, key_seed, block_in,
                 input ready);
  modport sink(input valid, action, table_index, table_word, key_seed, block_in,
               output ready);
endinterface

interface bfk_out_if import bfk_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [63:0] block_out;
  action_t     done_action;

  modport source(output valid, block_out, done_action, input ready);
  modport sink(input valid, block_out, done_action, output ready);
endinterface

// File: rtl/bfk_sram.sv
// Generic synchronous RAM: one write port, two read ports with registered data.
module bfk_sram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_a_r <= mem_r[raddr_a];
    rdata_b_r <= mem_r[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// File: rtl/bfk_feistel.sv
// Iterative 16-round Feistel unit; two S-box lookups per cycle.
module bfk_feistel import bfk_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  half_pair_t      blk_in,
  input  p_words_t        p_words,
  output logic [S_AW-1:0] s_addr_a,
  output logic [S_AW-1:0] s_addr_b,
  input  logic [31:0]     s_data_a,
  input  logic [31:0]     s_data_b,
  output logic            done,
  output half_pair_t      blk_out
);

  typedef enum logic [1:0] {FS_IDLE, FS_ISSUE, FS_FETCH, FS_MIX} fs_state_t;

  fs_state_t          st_r;
  logic [31:0]        l_r;
  logic [31:0]        r_r;
  logic [31:0]        ab_r;
  logic [ROUND_W-1:0] round_r;
  logic               done_r;
  half_pair_t         blk_out_r;

  logic [31:0] lx;
  logic [31:0] f_val;
  logic [31:0] new_l;

  // Reads for boxes 0 and 1 go out in one cycle, boxes 2 and 3 in the next.
  always_comb begin
    lx    = l_r ^ p_words[0];
    f_val = (ab_r ^ s_data_a) + s_data_b;
    new_l = r_r ^ f_val ^ p_words[P_IW'(round_r) + P_IW'(1)];
    case (st_r)
      FS_ISSUE: begin
        s_addr_a = {2'd0, lx[31:24]};
        s_addr_b = {2'd1, lx[23:16]};
      end
      FS_FETCH: begin
        s_addr_a = {2'd2, l_r[15:8]};
        s_addr_b = {2'd3, l_r[7:0]};
      end
      FS_MIX: begin
        s_addr_a = {2'd0, new_l[31:24]};
        s_addr_b = {2'd1, new_l[23:16]};
      end
      default: begin
        s_addr_a = '0;
        s_addr_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= FS_IDLE;
      done_r <= 1'b0;
    end else begin
      done_r <= (st_r == FS_MIX) && (round_r == ROUND_W'(ROUNDS - 1));
      case (st_r)
        FS_IDLE: begin
          if (start) begin
            l_r     <= blk_in.l;
            r_r     <= blk_in.r;
            round_r <= '0;
            st_r    <= FS_ISSUE;
          end
        end
        FS_ISSUE: begin
          l_r  <= lx;
          st_r <= FS_FETCH;
        end
        FS_FETCH: begin
          ab_r <= s_data_a + s_data_b;
          st_r <= FS_MIX;
        end
        FS_MIX: begin
          if (round_r == ROUND_W'(ROUNDS - 1)) begin
            blk_out_r.l <= l_r ^ p_words[P_WORDS-1];
            blk_out_r.r <= r_r ^ f_val ^ p_words[ROUNDS];
            st_r        <= FS_IDLE;
          end else begin
            l_r     <= new_l;
            r_r     <= l_r;
            round_r <= round_r + ROUND_W'(1);
            st_r    <= FS_FETCH;
          end
        end
        default: st_r <= FS_IDLE;
      endcase
    end
  end

  assign done    = done_r;
  assign blk_out = blk_out_r;

endmodule

// File: rtl/blowfish_keycode_cipher_engine.sv
// Top level of the Blowfish keycode engine: command sequencer, P array and S-box RAM.
//
// Input words arrive on in_ch (valid/ready) and carry one action each: load one
// table word, run the keycode schedule, or encrypt one 64-bit block. Every input
// word yields exactly one result word on out_ch: the ciphertext for an encrypt,
// zero otherwise, with the action code echoed.
// cfg_we/cfg_wdata write key_level, the number of schedule passes; write it
// only while the engine is idle.
// One word is handled at a time. A load or an unknown action passes through the
// response state, and the next word is accepted once the engine is back in idle.
// An encryption waits in ST_ENC for the Feistel unit, whose rounds are paced by
// the two lookups per cycle of the S-box RAM.
// A schedule pass runs 523 chained encryptions, plus a write in ST_KSW for the
// second word of each S-box pair.
// The result sits in an output register; a new input word is accepted while it
// waits, and a stalled receiver only holds back the next result.
// Reset (rst_n low, synchronous) returns to idle, drops out_ch.valid and sets
// key_level to 2. Table contents are undefined until loaded.
module blowfish_keycode_cipher_engine import bfk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  bfk_in_if.sink      in_ch,
  bfk_out_if.source   out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_wdata
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_ENC, ST_KE1, ST_KE2, ST_KXOR, ST_KP, ST_KS, ST_KSW, ST_RESP
  } state_t;

  state_t      st_r;
  p_words_t    p_r;
  logic [1:0]  key_level_r;
  logic [31:0] k0_r;
  logic [31:0] k1_r;
  logic [31:0] k2_r;
  logic [1:0]  lv_r;
  logic [8:0]  j_r;
  logic [63:0] res_blk_r;
  action_t     res_act_r;
  logic        out_valid_r;
  logic [63:0] out_blk_r;
  action_t     out_act_r;
  logic        fs_start_r;
  half_pair_t  fs_blk_r;

  logic            in_acc;
  logic            resp_go;
  logic            fs_start_nxt;
  logic            fs_done;
  half_pair_t      fs_out;
  logic [S_AW-1:0] s_raddr_a;
  logic [S_AW-1:0] s_raddr_b;
  logic [31:0]     s_rdata_a;
  logic [31:0]     s_rdata_b;
  logic            s_we;
  logic [S_AW-1:0] s_waddr;
  logic [31:0]     s_wdata;
  logic [10:0]     s_lidx;

  assign in_ch.ready = (st_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign s_lidx      = in_ch.table_index - 11'(P_WORDS);
  assign resp_go     = (st_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  always_comb begin
    s_we    = 1'b0;
    s_waddr = '0;
    s_wdata = '0;
    if (in_acc && in_ch.action == ACT_LOAD && in_ch.table_index >= 11'(P_WORDS) &&
        in_ch.table_index < 11'(TABLE_WORDS)) begin
      s_we    = 1'b1;
      s_waddr = s_lidx[S_AW-1:0];
      s_wdata = in_ch.table_word;
    end else if (st_r == ST_KS && fs_done) begin
      s_we    = 1'b1;
      s_waddr = {j_r, 1'b0};
      s_wdata = fs_out.l;
    end else if (st_r == ST_KSW) begin
      s_we    = 1'b1;
      s_waddr = {j_r, 1'b1};
      s_wdata = fs_out.r;
    end
  end

  // Every step that hands a block to the Feistel unit raises start for one cycle.
  always_comb begin
    case (st_r)
      ST_IDLE: fs_start_nxt = in_acc && (in_ch.action == ACT_ENC ||
                              (in_ch.action == ACT_KEY && key_level_r != 2'd0));
      ST_KE1:  fs_start_nxt = fs_done;
      ST_KP:   fs_start_nxt = fs_done;
      ST_KXOR: fs_start_nxt = 1'b1;
      ST_KSW:  fs_start_nxt = (j_r != 9'(S_WORDS / 2 - 1)) ||
                              (lv_r + 2'd1 != key_level_r);
      default: fs_start_nxt = 1'b0;
    endcase
  end

  bfk_sram #(.WIDTH(32), .DEPTH(S_WORDS)) u_sbox (
    .clk     (clk),
    .we      (s_we),
    .waddr   (s_waddr),
    .wdata   (s_wdata),
    .raddr_a (s_raddr_a),
    .raddr_b (s_raddr_b),
    .rdata_a (s_rdata_a),
    .rdata_b (s_rdata_b)
  );

  bfk_feistel u_feistel (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (fs_start_r),
    .blk_in   (fs_blk_r),
    .p_words  (p_r),
    .s_addr_a (s_raddr_a),
    .s_addr_b (s_raddr_b),
    .s_data_a (s_rdata_a),
    .s_data_b (s_rdata_b),
    .done     (fs_done),
    .blk_out  (fs_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      out_valid_r <= 1'b0;
      key_level_r <= 2'd2;
      fs_start_r  <= 1'b0;
    end else begin
      fs_start_r <= fs_start_nxt;
      if (cfg_we) begin
        key_level_r <= cfg_wdata;
      end
      if (resp_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (st_r)
        ST_IDLE: begin
          if (in_acc) begin
            res_act_r <= in_ch.action;
            res_blk_r <= '0;
            case (in_ch.action)
              ACT_LOAD: begin
                if (in_ch.table_index < 11'(P_WORDS)) begin
                  p_r[in_ch.table_index[P_IW-1:0]] <= in_ch.table_word;
                end
                st_r <= ST_RESP;
              end
              ACT_KEY: begin
                k0_r <= in_ch.key_seed;
                k1_r <= in_ch.key_seed >> 1;
                k2_r <= in_ch.key_seed << 1;
                lv_r <= '0;
                if (key_level_r == 2'd0) begin
                  st_r <= ST_RESP;
                end else begin
                  fs_blk_r <= '{l: in_ch.key_seed << 1, r: in_ch.key_seed >> 1};
                  st_r     <= ST_KE1;
                end
              end
              ACT_ENC: begin
                fs_blk_r <= '{l: in_ch.block_in[63:32], r: in_ch.block_in[31:0]};
                st_r     <= ST_ENC;
              end
              default: st_r <= ST_RESP;
            endcase
          end
        end
        ST_ENC: begin
          if (fs_done) begin
            res_blk_r <= {fs_out.l, fs_out.r};
            st_r      <= ST_RESP;
          end
        end
        ST_KE1: begin
          if (fs_done) begin
            k2_r     <= fs_out.l;
            k1_r     <= fs_out.r;
            fs_blk_r <= '{l: fs_out.r, r: k0_r};
            st_r     <= ST_KE2;
          end
        end
        ST_KE2: begin
          if (fs_done) begin
            k1_r <= fs_out.l;
            k0_r <= fs_out.r;
            st_r <= ST_KXOR;
          end
        end
        ST_KXOR: begin
          for (int i = 0; i < P_WORDS; i++) begin
            p_r[i] <= p_r[i] ^ swap_bytes((i % 2 == 1) ? k1_r : k0_r);
          end
          fs_blk_r <= '0;
          j_r      <= '0;
          st_r     <= ST_KP;
        end
        ST_KP: begin
          if (fs_done) begin
            p_r[{j_r[P_IW-2:0], 1'b0}] <= fs_out.l;
            p_r[{j_r[P_IW-2:0], 1'b1}] <= fs_out.r;
            fs_blk_r <= fs_out;
            if (j_r == 9'(P_WORDS / 2 - 1)) begin
              j_r  <= '0;
              st_r <= ST_KS;
            end else begin
              j_r <= j_r + 9'd1;
            end
          end
        end
        ST_KS: begin
          if (fs_done) begin
            st_r <= ST_KSW;
          end
        end
        ST_KSW: begin
          if (j_r == 9'(S_WORDS / 2 - 1)) begin
            lv_r <= lv_r + 2'd1;
            j_r  <= '0;
            if (lv_r + 2'd1 == key_level_r) begin
              st_r <= ST_RESP;
            end else begin
              fs_blk_r <= '{l: k2_r, r: k1_r};
              st_r     <= ST_KE1;
            end
          end else begin
            j_r      <= j_r + 9'd1;
            fs_blk_r <= fs_out;
            st_r     <= ST_KS;
          end
        end
        ST_RESP: begin
          if (resp_go) begin
            out_blk_r <= res_blk_r;
            out_act_r <= res_act_r;
            st_r      <= ST_IDLE;
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.block_out   = out_blk_r;
  assign out_ch.done_action = out_act_r;

  // The Feistel unit only finishes while the sequencer waits for it.
  a_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    fs_done |-> (st_r == ST_ENC || st_r == ST_KE1 || st_r == ST_KE2 ||
                 st_r == ST_KP || st_r == ST_KS))
    else $error("feistel finished while not awaited");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r != ST_IDLE)
    else $error("accepted word did not start work");

  // A plain encryption never modifies the S-boxes.
  a_no_write_in_enc: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_ENC) |-> !s_we)
    else $error("S-box write during encryption");

  a_single_start: assert property (@(posedge clk) disable iff (!rst_n)
    fs_start_r |=> !fs_start_r)
    else $error("feistel start held for two cycles");

endmodule
